/* rtl/plid_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// Package for the positional list unit: sizes, command/status codes,
// cell modes and the transaction structs. No dependencies.
package plid_pkg;

  localparam int CAPACITY    = 16;
  localparam int MAX_RESULTS = 16;

  localparam int DATA_W  = 32;
  localparam int POS_W   = 5;
  localparam int OCNT_W  = 5;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W + 1 : POS_W + 1;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;
  localparam logic [1:0] CMD_DUMP   = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  // per-cell update source
  localparam logic [1:0] MODE_HOLD = 2'd0;
  localparam logic [1:0] MODE_LOW  = 2'd1;  // from lower neighbour
  localparam logic [1:0] MODE_HIGH = 2'd2;  // from upper neighbour
  localparam logic [1:0] MODE_LOAD = 2'd3;

  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [DATA_W-1:0] elem_value;
    logic [POS_W-1:0]         position;
  } plid_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] elem_out;
    logic [OCNT_W-1:0]        count_now;
    logic                     last;
  } plid_out_t;

endpackage : plid_pkg
`default_nettype wire

/* rtl/plid_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// One element cell of the list chain: holds a value, takes it from a
// neighbour or a load bus as the mode says. Depends on plid_pkg.
module plid_cell (
  input  wire logic                               clk,
  input  wire logic [1:0]                         mode,
  input  wire logic signed [plid_pkg::DATA_W-1:0] low_val,
  input  wire logic signed [plid_pkg::DATA_W-1:0] high_val,
  input  wire logic signed [plid_pkg::DATA_W-1:0] load_val,
  output logic signed [plid_pkg::DATA_W-1:0]      q
);

  logic signed [plid_pkg::DATA_W-1:0] val_r, val_nxt;

  always_comb begin
    case (mode)
      plid_pkg::MODE_LOW:  val_nxt = low_val;
      plid_pkg::MODE_HIGH: val_nxt = high_val;
      plid_pkg::MODE_LOAD: val_nxt = load_val;
      default:             val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign q = val_r;

endmodule : plid_cell
`default_nettype wire

/* rtl/positional_list_insert_delete_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Top level of the positional list unit: control, output register and the
// chain of plid_cell elements. Depends on plid_pkg and plid_cell.
//
//  Channel | Ports                         | Carries
//  --------+-------------------------------+-------------------------------
//  input   | in_valid, in_ready, in_data   | plid_in_t: cmd, value, position
//  result  | out_valid, out_ready, out_data| plid_out_t: status, elem, count
//
// Append, insert and delete act on all cells at once: every cell shifts in parallel,
// so such a transaction can be taken each cycle while the result slot drains.
// A dump first accepts the command, then holds the input off while the
// occupied cells rotate towards cell 0, which is read out each cycle that the
// result slot is free, so the order is restored at the end.
// rst_n (synchronous) empties the list; cell contents are not cleared.
// Result back-pressure stalls both edits and the dump rotation.
module positional_list_insert_delete_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire plid_pkg::plid_in_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output plid_pkg::plid_out_t     out_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic [plid_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [plid_pkg::CNT_W-1:0] idx_r, idx_nxt;
  logic                       st_r, st_nxt;
  logic                       out_valid_r, out_valid_nxt;
  plid_pkg::plid_out_t        out_r, out_nxt;

  logic signed [plid_pkg::DATA_W-1:0] cell_q   [plid_pkg::CAPACITY];
  logic signed [plid_pkg::DATA_W-1:0] cell_ld  [plid_pkg::CAPACITY];
  logic [1:0]                         cell_mode[plid_pkg::CAPACITY];

  logic                       slot_free, acc;
  logic                       do_ins, do_del, do_rot;
  logic [plid_pkg::CMP_W-1:0] pos_ext, cnt_ext, edit_pos;
  logic [plid_pkg::CNT_W-1:0] dump_n;
  logic [1:0]                 stat;

  always_comb begin
    slot_free     = !out_valid_r || out_ready;
    in_ready      = (st_r == ST_IDLE) && slot_free;
    acc           = in_valid && in_ready;
    pos_ext       = plid_pkg::CMP_W'(in_data.position);
    cnt_ext       = plid_pkg::CMP_W'(cnt_r);
    edit_pos      = (in_data.cmd == plid_pkg::CMD_APPEND) ? cnt_ext : pos_ext;
    dump_n        = (int'(cnt_r) > plid_pkg::MAX_RESULTS) ?
                    plid_pkg::CNT_W'(plid_pkg::MAX_RESULTS) : cnt_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    do_ins        = 1'b0;
    do_del        = 1'b0;
    do_rot        = 1'b0;
    stat          = plid_pkg::STAT_OK;

    if (acc) begin
      case (in_data.cmd)
        plid_pkg::CMD_APPEND, plid_pkg::CMD_INSERT: begin
          if (cnt_r == plid_pkg::CNT_W'(plid_pkg::CAPACITY)) begin
            stat = plid_pkg::STAT_FULL;
          end else if (edit_pos > cnt_ext) begin
            stat = plid_pkg::STAT_RANGE;
          end else begin
            do_ins  = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        plid_pkg::CMD_DELETE: begin
          if (pos_ext >= cnt_ext) begin
            stat = plid_pkg::STAT_RANGE;
          end else begin
            do_del  = 1'b1;
            cnt_nxt = cnt_r - 1'b1;
          end
        end
        default: begin
          // dump: an empty list answers at once, otherwise start rotating
          if (cnt_r == '0) begin
            stat = plid_pkg::STAT_RANGE;
          end else begin
            st_nxt  = ST_DUMP;
            idx_nxt = '0;
          end
        end
      endcase
      if (!(in_data.cmd == plid_pkg::CMD_DUMP && cnt_r != '0)) begin
        out_valid_nxt     = 1'b1;
        out_nxt.status    = stat;
        out_nxt.elem_out  = '0;
        out_nxt.count_now = plid_pkg::OCNT_W'(cnt_nxt);
        out_nxt.last      = 1'b1;
      end
    end else if (st_r == ST_DUMP && slot_free) begin
      do_rot  = 1'b1;
      idx_nxt = idx_r + 1'b1;
      if (idx_r < dump_n) begin
        out_valid_nxt     = 1'b1;
        out_nxt.status    = plid_pkg::STAT_OK;
        out_nxt.elem_out  = cell_q[0];
        out_nxt.count_now = plid_pkg::OCNT_W'(cnt_r);
        out_nxt.last      = (idx_r + 1'b1 == dump_n);
      end
      // rotation continues past the emitted elements so the order comes back
      if (idx_r + 1'b1 == cnt_r) begin
        st_nxt = ST_IDLE;
      end
    end
  end

  // per-cell source selection
  always_comb begin
    for (int i = 0; i < plid_pkg::CAPACITY; i++) begin
      cell_mode[i] = plid_pkg::MODE_HOLD;
      cell_ld[i]   = in_data.elem_value;
      if (do_ins) begin
        if (plid_pkg::CMP_W'(i) > edit_pos) begin
          cell_mode[i] = plid_pkg::MODE_LOW;
        end else if (plid_pkg::CMP_W'(i) == edit_pos) begin
          cell_mode[i] = plid_pkg::MODE_LOAD;
        end
      end else if (do_del) begin
        if (plid_pkg::CMP_W'(i) >= pos_ext) begin
          cell_mode[i] = plid_pkg::MODE_HIGH;
        end
      end else if (do_rot) begin
        if (plid_pkg::CMP_W'(i + 1) < cnt_ext) begin
          cell_mode[i] = plid_pkg::MODE_HIGH;
        end else if (plid_pkg::CMP_W'(i + 1) == cnt_ext) begin
          cell_mode[i] = plid_pkg::MODE_LOAD;
          cell_ld[i]   = cell_q[0];
        end
      end
    end
  end

  for (genvar g = 0; g < plid_pkg::CAPACITY; g++) begin : g_cell
    logic signed [plid_pkg::DATA_W-1:0] low_v, high_v;
    if (g == 0) begin : g_first
      assign low_v = cell_q[g];
    end else begin : g_low
      assign low_v = cell_q[g-1];
    end
    if (g == plid_pkg::CAPACITY - 1) begin : g_top
      assign high_v = cell_q[g];
    end else begin : g_high
      assign high_v = cell_q[g+1];
    end
    plid_cell u_cell (
      .clk      (clk),
      .mode     (cell_mode[g]),
      .low_val  (low_v),
      .high_val (high_v),
      .load_val (cell_ld[g]),
      .q        (cell_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      idx_r       <= '0;
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule : positional_list_insert_delete_unit
`default_nettype wire

/* sim/tb_positional_list_insert_delete_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for positional_list_insert_delete_unit: a mirrored list
// predicts every result of append/insert/delete/dump, checked in order at the output.
// Depends on plid_pkg and the unit's RTL only.
module tb_positional_list_insert_delete_unit;
  import plid_pkg::*;

  localparam int QUIET_LIMIT  = 5000;  // cycles with no transaction on either side
  localparam int SETTLE_CYCLES = 20;   // covers the dump rotation restore
  localparam int PHASE_ITEMS  = 115;
  localparam int PRINT_CAP    = 100;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  plid_in_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  plid_out_t out_data;

  // mirror of the list contents and the results still owed by the unit
  logic signed [DATA_W-1:0] list_mirror[$];
  plid_out_t                pending_results[$];

  int mismatch_count = 0;
  int results_seen   = 0;
  int commands_sent  = 0;
  int dumps_sent     = 0;
  int peak_fill      = 0;
  int status_hits[3] = '{0, 0, 0};
  int quiet_cycles   = 0;

  // receiver controls, set by the tests
  int   holdoff_left = 0;
  bit   rx_stalls    = 1'b0;
  int   rx_run_left  = 0;
  logic rx_run_ready = 1'b1;

  always #1 clk = ~clk;

  positional_list_insert_delete_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  task automatic note_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // works out the results of one accepted command and updates the mirror
  task automatic mirror_apply(input plid_in_t item);
    plid_out_t r;
    int        fill;
    int        pos;
    int        n;
    fill = list_mirror.size();
    pos  = int'(item.position);
    r = '0;
    r.last = 1'b1;
    case (item.cmd)
      CMD_APPEND, CMD_INSERT: begin
        if (item.cmd == CMD_APPEND) pos = fill;
        // full is checked before the position
        if (fill >= CAPACITY) r.status = STAT_FULL;
        else if (pos > fill) r.status = STAT_RANGE;
        else begin
          list_mirror.insert(pos, item.elem_value);
          r.status = STAT_OK;
        end
        r.count_now = OCNT_W'(list_mirror.size());
        pending_results.push_back(r);
        status_hits[r.status]++;
      end
      CMD_DELETE: begin
        if (pos >= fill) r.status = STAT_RANGE;
        else begin
          list_mirror.delete(pos);
          r.status = STAT_OK;
        end
        r.count_now = OCNT_W'(list_mirror.size());
        pending_results.push_back(r);
        status_hits[r.status]++;
      end
      default: begin
        dumps_sent++;
        if (fill == 0) begin
          r.status = STAT_RANGE;
          pending_results.push_back(r);
          status_hits[STAT_RANGE]++;
        end else begin
          n = (fill > MAX_RESULTS) ? MAX_RESULTS : fill;
          for (int i = 0; i < n; i++) begin
            r.status    = STAT_OK;
            r.elem_out  = list_mirror[i];
            r.count_now = OCNT_W'(fill);
            r.last      = (i == n - 1);
            pending_results.push_back(r);
          end
          status_hits[STAT_OK]++;
        end
      end
    endcase
    if (list_mirror.size() > peak_fill) peak_fill = list_mirror.size();
  endtask

  // offers one transaction and returns at the edge that takes it; valid stays high
  task automatic send_item(input plid_in_t item);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    mirror_apply(item);
    commands_sent++;
  endtask

  task automatic idle_gap(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic pause_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic plid_in_t make_cmd(input logic [1:0] op, input logic signed [DATA_W-1:0] v,
                                        input int pos);
    plid_in_t c;
    c.cmd        = op;
    c.elem_value = v;
    c.position   = POS_W'(pos);
    return c;
  endfunction

  // mostly well-formed edits steered towards a fill target, plus dumps and noise
  function automatic plid_in_t pick_command(input int target);
    plid_in_t c;
    int       fill;
    int       roll;
    fill = list_mirror.size();
    roll = $urandom_range(0, 99);
    c.elem_value = $urandom();
    c.position   = '0;
    if (roll < 10) begin
      c.cmd = CMD_DUMP;
    end else if (roll < 20) begin
      c.cmd      = 2'($urandom_range(0, 3));
      c.position = POS_W'($urandom_range(0, 31));
    end else if (fill < target || (fill == target && roll < 55)) begin
      c.cmd      = (roll % 2) ? CMD_INSERT : CMD_APPEND;
      c.position = POS_W'($urandom_range(0, fill));
    end else begin
      c.cmd      = CMD_DELETE;
      c.position = (fill == 0) ? '0 : POS_W'($urandom_range(0, fill - 1));
    end
    return c;
  endfunction

  // field extremes, empty-list and out-of-range cases, ignored fields
  task automatic test_edge_cases();
    send_item(make_cmd(CMD_DUMP,   -1, 31));          // dump of empty list
    send_item(make_cmd(CMD_DELETE, -1, 0));           // delete on empty list
    send_item(make_cmd(CMD_DELETE, 0, 31));
    send_item(make_cmd(CMD_INSERT, 5, 1));            // insert past the end
    send_item(make_cmd(CMD_INSERT, 32'sh8000_0000, 0));
    send_item(make_cmd(CMD_APPEND, 32'sh7fff_ffff, 31)); // position ignored
    send_item(make_cmd(CMD_INSERT, 0, 2));            // insert at the end
    send_item(make_cmd(CMD_INSERT, -1, 1));
    send_item(make_cmd(CMD_INSERT, 7, 5));
    send_item(make_cmd(CMD_INSERT, 7, 31));
    send_item(make_cmd(CMD_INSERT, 32'sh5a5a_5a5a, 2));
    send_item(make_cmd(CMD_DUMP,   32'sh1234_5678, 16));
    send_item(make_cmd(CMD_DELETE, -1, 4));           // last element
    send_item(make_cmd(CMD_DELETE, 32'sh7fff_ffff, 0));
    send_item(make_cmd(CMD_DELETE, 0, 3));            // position equal to count
    send_item(make_cmd(CMD_DELETE, 0, 16));
    send_item(make_cmd(CMD_DUMP,   0, 0));
    send_item(make_cmd(CMD_DELETE, 0, 1));
    send_item(make_cmd(CMD_DELETE, 0, 0));
    send_item(make_cmd(CMD_DELETE, 0, 0));
    send_item(make_cmd(CMD_DUMP,   0, 0));
  endtask

  // receiver holds off while the sender fills the list and keeps appending past capacity
  task automatic test_backpressure();
    pause_until_drained();
    holdoff_left = 400;
    repeat (CAPACITY + 4) send_item(make_cmd(CMD_APPEND, $urandom(), $urandom_range(0, 31)));
    send_item(make_cmd(CMD_INSERT, $urandom(), 31));  // full wins over position
    send_item(make_cmd(CMD_INSERT, $urandom(), 0));
    send_item(make_cmd(CMD_DUMP, 0, 0));              // longest dump
    pause_until_drained();
  endtask

  // four phases: sender gaps and receiver stalls each off and on
  task automatic test_random_traffic();
    int  sent;
    int  burst_left;
    int  target;
    bit  tx_gaps;
    for (int ph = 0; ph < 4; ph++) begin
      tx_gaps    = ph[0];
      rx_stalls  = ph[1];
      sent       = 0;
      target     = 0;
      burst_left = $urandom_range(1, 12);
      while (sent < PHASE_ITEMS) begin
        if (sent % 24 == 0) target = $urandom_range(0, CAPACITY);
        send_item(pick_command(target));
        sent++;
        if (tx_gaps) begin
          burst_left--;
          if (burst_left == 0) begin
            idle_gap($urandom_range(1, 8));
            burst_left = $urandom_range(1, 12);
          end
        end
      end
    end
    rx_stalls = 1'b0;
  endtask

  // receiver: forced hold-off first, else runs of ready/stall of random length
  always @(negedge clk) begin
    if (holdoff_left > 0) begin
      out_ready <= 1'b0;
      holdoff_left--;
    end else if (!rx_stalls) begin
      out_ready <= 1'b1;
    end else begin
      if (rx_run_left == 0) begin
        rx_run_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                   : $urandom_range(1, 6);
        rx_run_ready = ($urandom_range(0, 99) < 60);
      end
      out_ready <= rx_run_ready;
      rx_run_left--;
    end
  end

  always @(posedge clk) begin
    plid_out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("result %0d arrived with nothing outstanding", results_seen));
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status)
          note_mismatch($sformatf("result %0d: status %0d, wanted %0d",
                                  results_seen, out_data.status, want.status));
        if (out_data.elem_out !== want.elem_out)
          note_mismatch($sformatf("result %0d: elem_out %0d, wanted %0d",
                                  results_seen, out_data.elem_out, want.elem_out));
        if (out_data.count_now !== want.count_now)
          note_mismatch($sformatf("result %0d: count_now %0d, wanted %0d",
                                  results_seen, out_data.count_now, want.count_now));
        if (out_data.last !== want.last)
          note_mismatch($sformatf("result %0d: last %0b, wanted %0b",
                                  results_seen, out_data.last, want.last));
      end
    end
  end

  // watchdog: a hang shows up as a long run with no transaction at all
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timed out with %0d results outstanding", pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_edge_cases();
    test_backpressure();
    test_random_traffic();
    pause_until_drained();
    if (pending_results.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    $display("Covered %0d commands (%0d dumps), %0d results checked, peak fill %0d of %0d",
             commands_sent, dumps_sent, results_seen, peak_fill, CAPACITY);
    $display("Edit outcomes: ok %0d, full %0d, out of range/empty %0d; %0d mismatches",
             status_hits[STAT_OK], status_hits[STAT_FULL], status_hits[STAT_RANGE],
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
